// ===== hdl/ppm_frame_decoder_top_assert.svh =====
// Assertion macros for the PPM frame decoder checker.
`ifndef PPM_FRAME_DECODER_TOP_ASSERT_SVH
`define PPM_FRAME_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPMFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppmfd same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PPMFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppmfd next-cycle check failed");

`endif

// ===== hdl/ppmfd_pkg.sv =====
// Types and constants shared by the PPM frame decoder files.
package ppmfd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_MIN         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_MAX         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_MIN        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_MAX        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_CEILING = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_LOW     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRENGTH_HIGH    = 3'd6;

    // Configuration reset values
    localparam logic [15:0] RST_SYNC_MIN         = 16'd5000;
    localparam logic [15:0] RST_SYNC_MAX         = 16'd20000;
    localparam logic [15:0] RST_PULSE_MIN        = 16'd900;
    localparam logic [15:0] RST_PULSE_MAX        = 16'd2100;
    localparam logic [5:0]  RST_STRENGTH_CEILING = 6'd20;
    localparam logic [5:0]  RST_STRENGTH_LOW     = 6'd5;
    localparam logic [5:0]  RST_STRENGTH_HIGH    = 6'd15;

    // Request mode bits
    localparam int MODE_BIT_TICK    = 0;
    localparam int MODE_BIT_CAPTURE = 1;

    localparam logic signed [2:0] OVERFLOW_LIMIT = 3'sd3;
    localparam logic signed [2:0] OVERFLOW_OK    = 3'sd1;
    localparam logic signed [2:0] OVERFLOW_RESET = -3'sd1;

    localparam logic [15:0] NEUTRAL_WIDTH    = 16'd1500;
    localparam logic [15:0] STABILIZE_BELOW  = 16'd1100;
    localparam logic [15:0] AUTO_ABOVE       = 16'd1400;
    localparam logic [15:0] AUTO_BELOW       = 16'd1600;
    localparam logic [15:0] MANUAL_ABOVE     = 16'd1900;

    localparam logic [1:0] FLIGHT_STABILIZE = 2'd0;
    localparam logic [1:0] FLIGHT_AUTO      = 2'd1;
    localparam logic [1:0] FLIGHT_MANUAL    = 2'd2;
    localparam logic [1:0] FLIGHT_UNDEFINED = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD       = 2'd1;
    localparam logic [1:0] STATUS_NO_SIGNAL = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] capture_time;
        logic [3:0]  read_channel;
    } ppmfd_in_t;

    typedef struct packed {
        logic [15:0] pulse_length;
        logic        stored_valid;
        logic [3:0]  stored_channel;
        logic        sync_found;
        logic [15:0] read_value;
        logic [1:0]  flight_mode;
        logic [1:0]  signal_status;
        logic [5:0]  strength;
    } ppmfd_out_t;

    function automatic logic [1:0] decode_flight_mode(input logic [15:0] width);
        logic [1:0] code;
        if (width < STABILIZE_BELOW)
            code = FLIGHT_STABILIZE;
        else if (width > AUTO_ABOVE && width < AUTO_BELOW)
            code = FLIGHT_AUTO;
        else if (width > MANUAL_ABOVE)
            code = FLIGHT_MANUAL;
        else
            code = FLIGHT_UNDEFINED;
        return code;
    endfunction

endpackage

// ===== hdl/ppm_frame_decoder_top.sv =====
// PPM pulse train decoder: capture timing, frame tracking, channel store and status.
// One request is taken every clock cycle while in_ready is high; its result appears in the
// output register on the cycle after acceptance, so throughput is one item per cycle,
// limited only by the single result register, which accepts a new request whenever it is
// empty or its current result is being taken. All state (last capture, overflow count,
// frame position, strength score, the CHANNELS channel widths) sits in flip-flops and is
// updated in the same cycle the request is accepted, so requests follow back to back.
// Reset clears the channel store at once; no clearing pass is needed.
module ppm_frame_decoder_top
    import ppmfd_pkg::*;
#(
    parameter int CHANNELS   = 7,
    parameter int MODE_INDEX = 4
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  ppmfd_in_t              in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ppmfd_out_t             out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W = $clog2(CHANNELS + 1);
    localparam int IDX_W = $clog2(CHANNELS);
    localparam logic [POS_W-1:0] POS_IDLE      = POS_W'(CHANNELS);
    localparam bit               MODE_IN_RANGE = MODE_INDEX < CHANNELS;
    localparam logic [IDX_W-1:0] MODE_SLOT     = IDX_W'(MODE_INDEX % CHANNELS);

    logic [15:0] sync_min_reg, sync_max_reg, pulse_min_reg, pulse_max_reg;
    logic [5:0]  ceiling_reg, strength_low_reg, strength_high_reg;

    logic [15:0]       last_capture_reg, last_capture_next;
    logic signed [2:0] ovf_count_reg, ovf_count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [5:0]        score_reg, score_next;
    logic [15:0]       width_reg  [CHANNELS];
    logic [15:0]       width_next [CHANNELS];

    logic       out_valid_reg;
    ppmfd_out_t out_data_reg, out_data_next;

    logic             accept;
    logic             capture;
    logic [15:0]      length;
    logic             st_valid;
    logic [POS_W-1:0] st_chan;
    logic             sync;
    logic             score_up, score_down;
    logic [5:0]       score_top;
    logic [6:0]       score_inc;
    logic [5:0]       score_mid;
    logic [15:0]      read_width;
    logic [15:0]      mode_width;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign capture   = in_data.mode[MODE_BIT_CAPTURE];
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Timing, frame position and strength
    always_comb
    begin
        ovf_count_next    = ovf_count_reg;
        last_capture_next = last_capture_reg;
        pos_next          = pos_reg;
        score_mid         = score_reg;
        length            = '0;
        st_valid          = 1'b0;
        st_chan           = '0;
        sync              = 1'b0;
        score_up          = 1'b0;
        score_down        = 1'b0;

        if (in_data.mode[MODE_BIT_TICK] && ovf_count_reg < OVERFLOW_LIMIT)
            ovf_count_next = ovf_count_reg + 3'sd1;

        if (capture)
        begin
            if (ovf_count_next <= OVERFLOW_OK)
                length = in_data.capture_time - last_capture_reg;
            else
                score_mid = '0;
            last_capture_next = in_data.capture_time;
            ovf_count_next    = '0;

            if (pos_reg >= POS_IDLE)
            begin
                if (length >= sync_min_reg && length <= sync_max_reg)
                begin
                    pos_next = '0;
                    sync     = 1'b1;
                    score_up = 1'b1;
                end
                else
                    score_down = 1'b1;
            end
            else
            begin
                if (length >= pulse_min_reg && length <= pulse_max_reg)
                begin
                    st_valid = 1'b1;
                    st_chan  = pos_reg;
                    score_up = 1'b1;
                end
                else
                    score_down = 1'b1;
                pos_next = pos_reg + 1'b1;
            end
        end

        // Saturate one below the ceiling; a zero ceiling behaves as one
        score_top  = (ceiling_reg == '0) ? '0 : ceiling_reg - 6'd1;
        score_inc  = {1'b0, score_mid} + 7'd1;
        score_next = score_mid;
        if (score_up)
            score_next = (score_inc > {1'b0, score_top}) ? score_top : score_inc[5:0];
        else if (score_down && score_mid != '0)
            score_next = score_mid - 6'd1;
    end

    // Channel store and read-back of the updated store
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
            width_next[i] = width_reg[i];
        if (st_valid)
            width_next[st_chan[IDX_W-1:0]] = length;

        if (in_data.read_channel < 4'(CHANNELS))
            read_width = width_next[in_data.read_channel[IDX_W-1:0]];
        else
            read_width = NEUTRAL_WIDTH;

        mode_width = MODE_IN_RANGE ? width_next[MODE_SLOT] : NEUTRAL_WIDTH;
    end

    always_comb
    begin
        out_data_next.pulse_length   = length;
        out_data_next.stored_valid   = st_valid;
        out_data_next.stored_channel = 4'(st_chan);
        out_data_next.sync_found     = sync;
        out_data_next.read_value     = read_width;
        out_data_next.flight_mode    = decode_flight_mode(mode_width);
        if (score_next > strength_high_reg)
            out_data_next.signal_status = STATUS_OK;
        else if (score_next > strength_low_reg)
            out_data_next.signal_status = STATUS_BAD;
        else
            out_data_next.signal_status = STATUS_NO_SIGNAL;
        out_data_next.strength       = score_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_min_reg      <= RST_SYNC_MIN;
            sync_max_reg      <= RST_SYNC_MAX;
            pulse_min_reg     <= RST_PULSE_MIN;
            pulse_max_reg     <= RST_PULSE_MAX;
            ceiling_reg       <= RST_STRENGTH_CEILING;
            strength_low_reg  <= RST_STRENGTH_LOW;
            strength_high_reg <= RST_STRENGTH_HIGH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_MIN:         sync_min_reg      <= cfg_data;
                CFG_SYNC_MAX:         sync_max_reg      <= cfg_data;
                CFG_PULSE_MIN:        pulse_min_reg     <= cfg_data;
                CFG_PULSE_MAX:        pulse_max_reg     <= cfg_data;
                CFG_STRENGTH_CEILING: ceiling_reg       <= cfg_data[5:0];
                CFG_STRENGTH_LOW:     strength_low_reg  <= cfg_data[5:0];
                CFG_STRENGTH_HIGH:    strength_high_reg <= cfg_data[5:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_capture_reg <= '0;
            ovf_count_reg    <= OVERFLOW_RESET;
            pos_reg          <= POS_IDLE;
            score_reg        <= '0;
            for (int i = 0; i < CHANNELS; i++)
                width_reg[i] <= '0;
        end
        else if (accept)
        begin
            last_capture_reg <= last_capture_next;
            ovf_count_reg    <= ovf_count_next;
            pos_reg          <= pos_next;
            score_reg        <= score_next;
            for (int i = 0; i < CHANNELS; i++)
                width_reg[i] <= width_next[i];
        end
    end

    // Hold the result until taken; load a new one on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== hdl/ppmfd_checker.sv =====
// Port-level checker for the PPM frame decoder, bound to the top level.
module ppmfd_checker
    import ppmfd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input ppmfd_out_t out_data
);

`include "ppm_frame_decoder_top_assert.svh"

    // A stalled result must hold
    `PPMFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Every accepted request leaves a result in the next cycle
    `PPMFD_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)

    // An edge is either a sync or a stored channel, never both
    `PPMFD_ASSERT_SAME(a_sync_or_store, out_valid, !(out_data.sync_found && out_data.stored_valid))

    // No store means channel zero
    `PPMFD_ASSERT_SAME(a_chan_zero, out_valid && !out_data.stored_valid,
                       out_data.stored_channel == 4'd0)

endmodule

bind ppm_frame_decoder_top ppmfd_checker u_ppmfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
